### rtl/canrxq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the can receive frame queue
package canrxq_pkg;

   localparam int HEADER_W  = 43;
   localparam int PAYLOAD_W = 64;

   localparam logic [28:0] EXT_MASK = 29'h1FFFFFFF;
   localparam logic [10:0] STD_MASK = 11'h7FF;
   localparam logic [3:0]  LEN_MASK = 4'hF;
   localparam logic [7:0]  FMI_MASK = 8'hFF;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_CAPTURE
   } state_type;

   // stored frame header, ident in the lowest bits
   typedef struct packed {
      logic [7:0]  filter_index;
      logic [3:0]  length;
      logic        remote;
      logic        extended;
      logic [28:0] ident;
   } header_type;

endpackage

### rtl/canrxq_ram.sv
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read data
module canrxq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/canrxq_decode.sv
`timescale 1ns / 1ps
// decodes the raw mailbox identifier and length words into a frame header
module canrxq_decode (
   input  logic [31:0]             id_word,
   input  logic [15:0]             length_word,
   output canrxq_pkg::header_type  header
);

   logic        extended;
   logic [28:0] ident;

   assign extended = id_word[2];

   // standard frames keep only the top eleven bits of the word
   assign ident = extended ? (id_word[31:3] & canrxq_pkg::EXT_MASK)
                           : {18'b0, id_word[31:21] & canrxq_pkg::STD_MASK};

   always_comb begin
      header              = '0;
      header.ident        = ident;
      header.extended     = extended;
      header.remote       = id_word[1];
      header.length       = length_word[3:0] & canrxq_pkg::LEN_MASK;
      header.filter_index = length_word[15:8] & canrxq_pkg::FMI_MASK;
   end

endmodule

### rtl/can_frame_receive_queue.sv
`timescale 1ns / 1ps
// can receive frame queue: ring of decoded frames in two rams, head shown per word
// rsp_tvalid rises after the accepted request word has passed the lookup and capture states
// each request word passes update, ram read and result capture before the next is accepted
// a stalled result port holds the block in capture until the previous result word is taken
// reset clears indices, count, lost flag and handshake state; ram contents stay
module can_frame_receive_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // id_word[31:0], length_word[47:32], data_low_word[79:48], data_high_word[111:80]
   input  logic [111:0] req_tdata,
   // cmd[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // head_valid[0], head_ident[29:1], head_extended[30], head_remote[31],
   // head_length[35:32], head_filter_index[43:36], head_payload[107:44],
   // stored_count[112:108], lost_flag[113], zero fill up to bit 119
   output logic [119:0] rsp_tdata
);

   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   canrxq_pkg::state_type  state_ff, state_in;
   canrxq_pkg::cmd_type    cmd;
   canrxq_pkg::header_type push_header;
   canrxq_pkg::header_type rd_header;
   logic [canrxq_pkg::HEADER_W-1:0]  rd_header_bits;
   logic [canrxq_pkg::PAYLOAD_W-1:0] rd_payload;

   logic [IW-1:0] write_index_ff, write_index_in;
   logic [IW-1:0] read_index_ff, read_index_in;
   logic [CW-1:0] count_ff, count_in;
   logic          dropped_ff, dropped_in;

   logic accept, not_full, not_empty, mem_wr_en, mem_rd_en, load_rsp, push_full;

   logic                             rsp_valid_ff, rsp_valid_in;
   canrxq_pkg::header_type           rsp_header_ff;
   logic [canrxq_pkg::PAYLOAD_W-1:0] rsp_payload_ff;
   logic                             rsp_head_valid_ff;
   logic [4:0]                       rsp_count_ff;
   logic                             rsp_lost_ff;

   function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] idx);
      next_slot = (idx == IW'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   canrxq_decode u_decode (
      .id_word     (req_tdata[31:0]),
      .length_word (req_tdata[47:32]),
      .header      (push_header)
   );

   canrxq_ram #(
      .WIDTH (canrxq_pkg::HEADER_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_header_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (write_index_ff),
      .wr_data (push_header),
      .rd_en   (mem_rd_en),
      .rd_addr (read_index_ff),
      .rd_data (rd_header_bits)
   );

   canrxq_ram #(
      .WIDTH (canrxq_pkg::PAYLOAD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (write_index_ff),
      .wr_data ({req_tdata[111:80], req_tdata[79:48]}),
      .rd_en   (mem_rd_en),
      .rd_addr (read_index_ff),
      .rd_data (rd_payload)
   );

   assign rd_header = rd_header_bits;
   assign cmd       = canrxq_pkg::cmd_type'(req_tuser);
   assign not_full  = count_ff < CW'(QUEUE_DEPTH);
   assign not_empty = count_ff != '0;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         canrxq_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = canrxq_pkg::ST_LOOKUP;
         end
         canrxq_pkg::ST_LOOKUP: begin
            state_in = canrxq_pkg::ST_CAPTURE;
         end
         canrxq_pkg::ST_CAPTURE: begin
            if (!rsp_valid_ff || rsp_tready) state_in = canrxq_pkg::ST_IDLE;
         end
         default: begin
            state_in = canrxq_pkg::ST_IDLE;
         end
      endcase
   end

   // fsm outputs
   always_comb begin
      req_tready = 1'b0;
      mem_rd_en  = 1'b0;
      load_rsp   = 1'b0;
      unique case (state_ff)
         canrxq_pkg::ST_IDLE:    req_tready = 1'b1;
         canrxq_pkg::ST_LOOKUP:  mem_rd_en  = 1'b1;
         canrxq_pkg::ST_CAPTURE: load_rsp   = !rsp_valid_ff || rsp_tready;
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // queue bookkeeping, done at the accept edge
   always_comb begin
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      mem_wr_en      = 1'b0;
      push_full      = 1'b0;
      if (accept) begin
         unique case (cmd)
            canrxq_pkg::CMD_PUSH: begin
               if (not_full) begin
                  mem_wr_en      = 1'b1;
                  write_index_in = next_slot(write_index_ff);
                  count_in       = count_ff + 1'b1;
               end else begin
                  push_full  = 1'b1;
                  dropped_in = 1'b1;
               end
            end
            canrxq_pkg::CMD_POP: begin
               if (not_empty) begin
                  read_index_in = next_slot(read_index_ff);
                  count_in      = count_ff - 1'b1;
               end
            end
            canrxq_pkg::CMD_CLEAR: begin
               write_index_in = '0;
               read_index_in  = '0;
               count_in       = '0;
               dropped_in     = 1'b0;
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= canrxq_pkg::ST_IDLE;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         count_ff       <= '0;
         dropped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         count_ff       <= count_in;
         dropped_ff     <= dropped_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result word; an empty queue shows a zero head
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_head_valid_ff <= not_empty;
         rsp_header_ff     <= not_empty ? rd_header : '0;
         rsp_payload_ff    <= not_empty ? rd_payload : '0;
         rsp_count_ff      <= 5'(count_ff);
         rsp_lost_ff       <= dropped_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0,
                        rsp_lost_ff,
                        rsp_count_ff,
                        rsp_payload_ff,
                        rsp_header_ff.filter_index,
                        rsp_header_ff.length,
                        rsp_header_ff.remote,
                        rsp_header_ff.extended,
                        rsp_header_ff.ident,
                        rsp_head_valid_ff};

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("frame count above queue depth");

   a_write_has_room: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (not_full && accept))
      else $error("ram write without room in the queue");

   a_index_match: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CW'(QUEUE_DEPTH)) |-> write_index_ff == read_index_ff)
      else $error("ring indices disagree with the count");

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> mem_rd_en)
      else $error("accepted word not followed by a head read");

   a_lost_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(dropped_ff) |-> $past(push_full))
      else $error("lost flag set without a push to a full queue");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the can receive frame queue: random command stream, head checks
module tb;

   localparam int QUEUE_DEPTH = 16;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int TAIL_ITEMS = 100;
   localparam int IDLE_LIMIT = 500;
   localparam int RANDOM_ITEMS = 1150;

   // one request word waiting to be sent
   typedef struct {
      logic [1:0]   cmd;
      logic [111:0] data;
      bit           hold;
   } request_item_type;

   // matches the packing of rsp_tdata[113:0]
   typedef struct packed {
      logic        lost;
      logic [4:0]  count;
      logic [63:0] payload;
      logic [7:0]  filter_index;
      logic [3:0]  length;
      logic        remote;
      logic        extended;
      logic [28:0] ident;
      logic        valid;
   } head_word_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [111:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;

   can_frame_receive_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   request_item_type pending[$];
   head_word_type    head_expect[$];
   request_item_type next_item;
   head_word_type    want;
   head_word_type    got;

   // shadow of the queue
   canrxq_pkg::header_type hdr_mem [QUEUE_DEPTH];
   logic [63:0] pay_mem [QUEUE_DEPTH];
   int          wr_ptr = 0;
   int          rd_ptr = 0;
   int          fill = 0;
   logic        lost = 1'b0;

   int n_stored = 0, n_popped = 0, n_cleared = 0, n_dropped = 0, n_unused = 0;
   int max_fill = 0;
   int mismatches = 0;
   int checked_n = 0;
   int total_items = 0;
   int in_flight = 0;
   int send_gap = 0;
   int send_pct = 0;
   int recv_pct = 0;
   int stall_left = 0;
   int idle_cycles = 0;

   initial begin
      forever #6 clock = ~clock;
   end

   task automatic apply_command(input logic [1:0] cmd, input logic [111:0] d,
                                output head_word_type h);
      logic [31:0] idw;
      canrxq_pkg::header_type hd;
      idw = d[31:0];
      case (cmd)
         canrxq_pkg::CMD_PUSH: begin
            if (fill < QUEUE_DEPTH) begin
               hd.extended     = idw[2];
               hd.remote       = idw[1];
               hd.ident        = idw[2] ? idw[31:3] : {18'd0, idw[31:21]};
               hd.length       = d[35:32];
               hd.filter_index = d[47:40];
               hdr_mem[wr_ptr] = hd;
               pay_mem[wr_ptr] = d[111:48];
               wr_ptr = (wr_ptr + 1) % QUEUE_DEPTH;
               fill++;
               n_stored++;
               if (fill > max_fill) max_fill = fill;
            end else begin
               lost = 1'b1;
               n_dropped++;
            end
         end
         canrxq_pkg::CMD_POP: begin
            if (fill > 0) begin
               rd_ptr = (rd_ptr + 1) % QUEUE_DEPTH;
               fill--;
               n_popped++;
            end
         end
         canrxq_pkg::CMD_CLEAR: begin
            wr_ptr = 0;
            rd_ptr = 0;
            fill = 0;
            lost = 1'b0;
            n_cleared++;
         end
         CMD_UNUSED: n_unused++;
      endcase
      h = '0;
      if (fill > 0) begin
         h.valid        = 1'b1;
         h.ident        = hdr_mem[rd_ptr].ident;
         h.extended     = hdr_mem[rd_ptr].extended;
         h.remote       = hdr_mem[rd_ptr].remote;
         h.length       = hdr_mem[rd_ptr].length;
         h.filter_index = hdr_mem[rd_ptr].filter_index;
         h.payload      = pay_mem[rd_ptr];
      end
      h.count = fill[4:0];
      h.lost  = lost;
   endtask

   task automatic note_mismatch(input string what, input logic [63:0] exp_v,
                                input logic [63:0] act_v);
      mismatches++;
      if (mismatches <= 10)
         $display("tb: %s differs on result word %0d: expected %h, got %h",
                  what, checked_n, exp_v, act_v);
   endtask

   task automatic add_item(input logic [1:0] cmd, input logic [31:0] idw,
                           input logic [15:0] lenw, input logic [31:0] lo,
                           input logic [31:0] hi, input bit hold);
      request_item_type it;
      it.cmd  = cmd;
      it.data = {hi, lo, lenw, idw};
      it.hold = hold;
      pending.push_back(it);
   endtask

   task automatic add_random(input logic [1:0] cmd, input bit hold);
      add_item(cmd, $urandom, 16'($urandom_range(0, 65535)), $urandom, $urandom, hold);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending.size() == 0 ||
                      (pending[0].hold && (req_tvalid || in_flight != 0))) begin
            req_tvalid <= 1'b0;
         end else begin
            next_item = pending.pop_front();
            req_tdata <= next_item.data;
            req_tuser <= next_item.cmd;
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 39) == 0) send_pct <= $urandom_range(0, 2) * 20;
            if (pending.size() >= TAIL_ITEMS && $urandom_range(0, 99) < send_pct)
               send_gap <= $urandom_range(1, 5);
         end
      end
   end

   // monitor and result-side ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         in_flight <= 0;
         stall_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_command(req_tuser, req_tdata, want);
            head_expect.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[113:0];
            if (head_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("tb: result word %0d arrived with nothing expected: %h",
                           checked_n, rsp_tdata);
            end else begin
               want = head_expect.pop_front();
               if (got.valid !== want.valid)
                  note_mismatch("head_valid", want.valid, got.valid);
               if (got.ident !== want.ident)
                  note_mismatch("head_ident", want.ident, got.ident);
               if (got.extended !== want.extended)
                  note_mismatch("head_extended", want.extended, got.extended);
               if (got.remote !== want.remote)
                  note_mismatch("head_remote", want.remote, got.remote);
               if (got.length !== want.length)
                  note_mismatch("head_length", want.length, got.length);
               if (got.filter_index !== want.filter_index)
                  note_mismatch("head_filter_index", want.filter_index, got.filter_index);
               if (got.payload !== want.payload)
                  note_mismatch("head_payload", want.payload, got.payload);
               if (got.count !== want.count)
                  note_mismatch("stored_count", want.count, got.count);
               if (got.lost !== want.lost)
                  note_mismatch("lost_flag", want.lost, got.lost);
            end
            checked_n++;
         end
         in_flight <= head_expect.size();
         if ($urandom_range(0, 99) == 0) recv_pct <= $urandom_range(0, 2) * 15;
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (checked_n < total_items - TAIL_ITEMS &&
                      $urandom_range(0, 99) < recv_pct) begin
            stall_left = $urandom_range(1, 5) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int n;
      int mode;
      int pick;
      bit hold;

      // directed: empty pop, identifier extremes, unused command, drain, a clear
      add_random(canrxq_pkg::CMD_POP, 0);
      add_item(canrxq_pkg::CMD_PUSH, 32'hFFFF_FFF8, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      add_item(canrxq_pkg::CMD_PUSH, 32'hFFFF_FFFF, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0);
      add_item(canrxq_pkg::CMD_PUSH, 32'h0000_0002, 16'hFF0F, 32'h0123_4567, 32'h89AB_CDEF, 0);
      add_item(canrxq_pkg::CMD_PUSH, 32'h0000_0004, 16'h00F0, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 0);
      add_item(canrxq_pkg::CMD_PUSH, 32'h0000_0000, 16'h0000, 32'h0000_0000, 32'h0000_0000, 0);
      add_random(CMD_UNUSED, 0);
      repeat (6) add_random(canrxq_pkg::CMD_POP, 0);
      add_random(canrxq_pkg::CMD_PUSH, 0);
      add_random(canrxq_pkg::CMD_PUSH, 0);
      add_random(canrxq_pkg::CMD_CLEAR, 1);
      add_random(canrxq_pkg::CMD_POP, 0);

      // random sequences: fill bursts to overflow, drains, mixed traffic, lone clears or unused commands
      while (pending.size() < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         hold = ($urandom_range(0, 14) == 0);
         if (mode <= 3) begin
            n = $urandom_range(12, 30);
            repeat (n) begin
               add_random(($urandom_range(0, 9) == 0) ? canrxq_pkg::CMD_POP
                                                      : canrxq_pkg::CMD_PUSH, hold);
               hold = 0;
            end
         end else if (mode <= 6) begin
            n = $urandom_range(5, 20);
            repeat (n) begin
               add_random(($urandom_range(0, 6) == 0) ? canrxq_pkg::CMD_PUSH
                                                      : canrxq_pkg::CMD_POP, hold);
               hold = 0;
            end
         end else if (mode <= 8) begin
            n = $urandom_range(5, 15);
            repeat (n) begin
               pick = $urandom_range(0, 39);
               add_random(pick == 0 ? canrxq_pkg::CMD_CLEAR
                          : (pick < 20 ? canrxq_pkg::CMD_PUSH : canrxq_pkg::CMD_POP), hold);
               hold = 0;
            end
         end else begin
            add_random($urandom_range(0, 1) ? canrxq_pkg::CMD_CLEAR : CMD_UNUSED, hold);
         end
      end
      total_items = pending.size();

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending.size() != 0 || req_tvalid || in_flight != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (head_expect.size() != 0) begin
         $display("tb: %0d result words never arrived", head_expect.size());
         mismatches += head_expect.size();
      end
      $display("tb: %0d words sent, %0d results checked, queue filled to %0d",
               total_items, checked_n, max_fill);
      $display("tb: %0d frames stored, %0d popped, %0d dropped while full, %0d clears, %0d unused",
               n_stored, n_popped, n_dropped, n_cleared, n_unused);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
